/* hdl/bounded_priority_queue_fifo_ties_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded priority queue
// Clocked checks, with and without a reset gate; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_QUEUE_FIFO_TIES_CORE_MACROS_SVH
`define BOUNDED_PRIORITY_QUEUE_FIFO_TIES_CORE_MACROS_SVH

`ifndef SYNTHESIS
// check that holds at every edge out of reset
`define BPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// check that holds at every edge, reset included
`define BPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define BPQ_ASSERT(lbl, prop, msg)
`define BPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/bpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_pkg
// Types, codes and constants shared by the priority queue cells and top.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int DEPTH_DEFAULT = 5;
  localparam int ID_W          = 16;
  localparam int PRIO_W        = 8;
  localparam int STATUS_W      = 2;
  localparam int FILL_W        = 3;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_POP    = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } cell_op_t;

  localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, prio: '0, id: '0};

endpackage

/* hdl/bpq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq channel interfaces
// Valid/ready channels for operation requests and queue results.
// ----------------------------------------------------------------------------
interface bpq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [bpq_pkg::ID_W-1:0]    entry_id;
  logic [bpq_pkg::PRIO_W-1:0]  entry_priority;

  modport source (output valid, output mode, output entry_id, output entry_priority,
                  input ready);
  modport sink   (input valid, input mode, input entry_id, input entry_priority,
                  output ready);
endinterface

interface bpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpq_pkg::STATUS_W-1:0]  status;
  logic [bpq_pkg::ID_W-1:0]      popped_id;
  logic [bpq_pkg::PRIO_W-1:0]    popped_priority;
  logic [bpq_pkg::FILL_W-1:0]    fill_level;

  modport source (output valid, output status, output popped_id, output popped_priority,
                  output fill_level, input ready);
  modport sink   (input valid, input status, input popped_id, input popped_priority,
                  input fill_level, output ready);
endinterface

/* hdl/bpq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module bpq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  bpq_pkg::cell_op_t op,
  input  bpq_pkg::entry_t   prev_ent,
  input  logic              prev_ge,
  input  bpq_pkg::entry_t   next_ent,
  output bpq_pkg::entry_t   ent,
  output logic              ge
);

  logic                        valid_r, valid_nxt;
  logic [bpq_pkg::PRIO_W-1:0]  prio_r, prio_nxt;
  logic [bpq_pkg::ID_W-1:0]    id_r, id_nxt;

  // new entry lands behind every held entry of equal or higher priority
  assign ge = valid_r && (prio_r >= op.prio);

  assign ent = '{valid: valid_r, prio: prio_r, id: id_r};

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    id_nxt    = id_r;
    case (op.cmd)
      bpq_pkg::CMD_INSERT: begin
        if (!ge) begin
          if (prev_ge) begin
            valid_nxt = 1'b1;
            prio_nxt  = op.prio;
            id_nxt    = op.id;
          end else begin
            valid_nxt = prev_ent.valid;
            prio_nxt  = prev_ent.prio;
            id_nxt    = prev_ent.id;
          end
        end
      end
      bpq_pkg::CMD_POP: begin
        valid_nxt = next_ent.valid;
        prio_nxt  = next_ent.prio;
        id_nxt    = next_ent.id;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    id_r   <= id_nxt;
  end

endmodule

/* hdl/bounded_priority_queue_fifo_ties_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_fifo_ties_core
// Bounded max-priority queue, first-in-first-out among equal priorities.
// ----------------------------------------------------------------------------
// output: result registered, valid in the cycle after the operation beat is accepted
// throughput: one operation per cycle while results are taken; the bound is
//   the combinational compare-and-shift across the chain of DEPTH cells
// reset: synchronous, clears every cell's valid bit, the count and the output
//   valid flag; a new beat is accepted in the first cycle after reset
`include "bounded_priority_queue_fifo_ties_core_macros.svh"

module bounded_priority_queue_fifo_ties_core #(
  parameter int DEPTH = bpq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  bpq_in_if.sink     in_bus,
  bpq_out_if.source  out_bus
);

  localparam int CW = $clog2(DEPTH + 1);

  bpq_pkg::entry_t   ents [DEPTH];
  logic [DEPTH-1:0]  ge;
  logic [DEPTH-1:0]  vld_vec;
  logic [DEPTH-1:0]  vld_inc;
  logic [DEPTH-1:0]  order_ok;
  bpq_pkg::cell_op_t op;

  logic              accept;
  logic              full;
  logic              head_valid;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW+2:0]     cnt_ext;

  logic                             out_valid_r;
  logic [bpq_pkg::STATUS_W-1:0]     status_r, status_nxt;
  logic [bpq_pkg::ID_W-1:0]         pid_r, pid_nxt;
  logic [bpq_pkg::PRIO_W-1:0]       pprio_r, pprio_nxt;
  logic [bpq_pkg::FILL_W-1:0]       fill_r;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign full         = ents[DEPTH-1].valid;
  assign head_valid   = ents[0].valid;

  always_comb begin
    op.prio    = in_bus.entry_priority;
    op.id      = in_bus.entry_id;
    op.cmd     = bpq_pkg::CMD_IDLE;
    cnt_nxt    = cnt_r;
    status_nxt = bpq_pkg::ST_EMPTY;
    pid_nxt    = '0;
    pprio_nxt  = '0;
    if (in_bus.mode == bpq_pkg::MODE_INSERT) begin
      if (full) begin
        status_nxt = bpq_pkg::ST_DROPPED;
      end else begin
        status_nxt = bpq_pkg::ST_INSERTED;
        op.cmd     = accept ? bpq_pkg::CMD_INSERT : bpq_pkg::CMD_IDLE;
        cnt_nxt    = cnt_r + 1'b1;
      end
    end else if (head_valid) begin
      // head of the chain is the oldest of the highest priority
      status_nxt = bpq_pkg::ST_POPPED;
      pid_nxt    = ents[0].id;
      pprio_nxt  = ents[0].prio;
      op.cmd     = accept ? bpq_pkg::CMD_POP : bpq_pkg::CMD_IDLE;
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  assign cnt_ext = {3'b000, cnt_nxt};

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      bpq_pkg::entry_t prev_ent;
      bpq_pkg::entry_t next_ent;
      logic            prev_ge;

      if (i == 0) begin : g_head
        assign prev_ent = bpq_pkg::ENTRY_EMPTY;
        assign prev_ge  = 1'b1;
      end else begin : g_mid
        assign prev_ent = ents[i-1];
        assign prev_ge  = ge[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign next_ent    = bpq_pkg::ENTRY_EMPTY;
        assign order_ok[i] = 1'b1;
      end else begin : g_link
        assign next_ent    = ents[i+1];
        assign order_ok[i] = !ents[i+1].valid || (ents[i].valid &&
                             (ents[i].prio >= ents[i+1].prio));
      end

      assign vld_vec[i] = ents[i].valid;

      bpq_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .prev_ent (prev_ent),
        .prev_ge  (prev_ge),
        .next_ent (next_ent),
        .ent      (ents[i]),
        .ge       (ge[i])
      );
    end
  endgenerate

  assign vld_inc = vld_vec + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pid_r    <= pid_nxt;
      pprio_r  <= pprio_nxt;
      fill_r   <= cnt_ext[bpq_pkg::FILL_W-1:0];
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = status_r;
  assign out_bus.popped_id       = pid_r;
  assign out_bus.popped_priority = pprio_r;
  assign out_bus.fill_level      = fill_r;

  `BPQ_ASSERT(a_count_matches, $countones(vld_vec) == cnt_r, "count and valid cells disagree")
  `BPQ_ASSERT(a_valid_prefix, (vld_vec & vld_inc) == '0, "hole in the cell chain")
  `BPQ_ASSERT(a_sorted, &order_ok, "cell chain out of priority order")
  `BPQ_ASSERT(a_pop_shrinks, accept && op.cmd == bpq_pkg::CMD_POP |=> cnt_r == $past(cnt_r) - 1'b1, "pop did not remove one entry")

endmodule

/* tb/bpq_order_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_order_checker
// Watches the operation and result channels of the bounded priority queue.
// Keeps its own copy of the queue, works out the result of every accepted
// operation beat and compares it field by field with the result beats.
// ----------------------------------------------------------------------------
module bpq_order_checker
  import bpq_pkg::*;
#(
  parameter int DEPTH = bpq_pkg::DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  bpq_in_if    in_mon,
  bpq_out_if   out_mon,
  output int   fail_count,
  output int   open_count,
  output int   checked_count,
  output int   dropped_count,
  output int   empty_pop_count
);

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [FILL_W-1:0] fill;
  } outcome_t;

  // entries in arrival order, slots 0 .. held_n-1
  logic [ID_W-1:0]   held_id   [DEPTH];
  logic [PRIO_W-1:0] held_prio [DEPTH];
  int unsigned       held_n;

  outcome_t pending_outcomes [$];

  int n_fail    = 0;
  int n_open    = 0;
  int n_checked = 0;
  int n_dropped = 0;
  int n_empty   = 0;

  assign fail_count      = n_fail;
  assign open_count      = n_open;
  assign checked_count   = n_checked;
  assign dropped_count   = n_dropped;
  assign empty_pop_count = n_empty;

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    n_fail++;
  endtask

  task automatic queue_model_op(input mode_t m, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio, output outcome_t r);
    int unsigned best;
    int unsigned k;
    r = '{status: ST_INSERTED, id: '0, prio: '0, fill: '0};
    if (m == MODE_INSERT) begin
      if (held_n < DEPTH) begin
        held_id[held_n]   = id;
        held_prio[held_n] = prio;
        held_n++;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_DROPPED;
      end
    end else if (held_n == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // strict compare keeps the earliest entry on ties
      best = 0;
      for (k = 1; k < held_n; k++) begin
        if (held_prio[k] > held_prio[best]) best = k;
      end
      r.id   = held_id[best];
      r.prio = held_prio[best];
      for (k = best + 1; k < held_n; k++) begin
        held_id[k-1]   = held_id[k];
        held_prio[k-1] = held_prio[k];
      end
      held_n--;
      r.status = ST_POPPED;
    end
    r.fill = FILL_W'(held_n);
  endtask

  always @(posedge clk) begin : watch
    outcome_t got;
    outcome_t want;
    outcome_t nxt;
    if (!rst_n) begin
      held_n = 0;
      pending_outcomes.delete();
    end else begin
      // result beat first: it always belongs to an earlier operation
      if (out_mon.valid && out_mon.ready) begin
        got.status = status_t'(out_mon.status);
        got.id     = out_mon.popped_id;
        got.prio   = out_mon.popped_priority;
        got.fill   = out_mon.fill_level;
        if (pending_outcomes.size() == 0) begin
          report($sformatf("result beat with no operation outstanding, status %0d",
                           got.status));
        end else begin
          want = pending_outcomes.pop_front();
          n_checked++;
          if (got.status !== want.status)
            report($sformatf("status got %0d, expected %0d", got.status, want.status));
          if (got.id !== want.id)
            report($sformatf("popped_id got %h, expected %h", got.id, want.id));
          if (got.prio !== want.prio)
            report($sformatf("popped_priority got %h, expected %h", got.prio, want.prio));
          if (got.fill !== want.fill)
            report($sformatf("fill_level got %0d, expected %0d", got.fill, want.fill));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        queue_model_op(mode_t'(in_mon.mode), in_mon.entry_id, in_mon.entry_priority, nxt);
        if (nxt.status == ST_DROPPED) n_dropped++;
        if (nxt.status == ST_EMPTY) n_empty++;
        pending_outcomes.push_back(nxt);
      end
    end
    n_open = pending_outcomes.size();
  end

endmodule

/* tb/bounded_priority_queue_fifo_ties_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_fifo_ties_core_tb
// Drives insert and pop beats into the priority queue: a directed opening
// for full, empty and tie handling, then random traffic under several
// sender and receiver idle patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module bounded_priority_queue_fifo_ties_core_tb;
  import bpq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  logic clk = 1'b0;
  logic rst_n;

  bpq_in_if  in_bus ();
  bpq_out_if out_bus ();

  int fail_count;
  int open_count;
  int checked_count;
  int dropped_count;
  int empty_pop_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int n_sent         = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bounded_priority_queue_fifo_ties_core #(.DEPTH(DEPTH)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  bpq_order_checker #(.DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .fail_count      (fail_count),
    .open_count      (open_count),
    .checked_count   (checked_count),
    .dropped_count   (dropped_count),
    .empty_pop_count (empty_pop_count)
  );

  // offers one beat, with random gaps ahead of it, and waits for acceptance
  task automatic send_op(input mode_t m, input logic [ID_W-1:0] id,
                         input logic [PRIO_W-1:0] prio);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.mode           <= m;
    in_bus.entry_id       <= id;
    in_bus.entry_priority <= prio;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_random(input int count);
    int insert_pct;
    logic [PRIO_W-1:0] prio;
    mode_t m;
    insert_pct = 50;
    for (int i = 0; i < count; i++) begin
      // swing the mix so the queue keeps filling up and draining
      if (i % 16 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 25;
          1: insert_pct = 50;
          2: insert_pct = 75;
          default: insert_pct = 90;
        endcase
      end
      m = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP;
      // half of the priorities from a few values so ties are common
      if ($urandom_range(0, 1) != 0) prio = PRIO_W'($urandom_range(0, 255));
      else prio = PRIO_W'($urandom_range(0, 3) << 6);
      send_op(m, ID_W'($urandom_range(0, 65535)), prio);
    end
  endtask

  initial begin : receiver
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    in_bus.valid          = 1'b0;
    in_bus.mode           = MODE_INSERT;
    in_bus.entry_id       = '0;
    in_bus.entry_priority = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, field extremes, full drop, ties among equal priorities
    send_op(MODE_POP, 16'hFFFF, 8'hFF);
    send_op(MODE_INSERT, 16'h0000, 8'h00);
    send_op(MODE_INSERT, 16'hFFFF, 8'hFF);
    send_op(MODE_INSERT, 16'h1234, 8'h80);
    send_op(MODE_INSERT, 16'hA5A5, 8'h80);
    send_op(MODE_INSERT, 16'h5A5A, 8'h00);
    send_op(MODE_INSERT, 16'hBEEF, 8'hFF);
    for (int i = 0; i < DEPTH + 1; i++) send_op(MODE_POP, 16'h0000, 8'h00);
    for (int i = 0; i < DEPTH; i++) send_op(MODE_INSERT, ID_W'(i + 1), 8'h42);
    for (int i = 0; i < DEPTH; i++) send_op(MODE_POP, 16'h0000, 8'h00);

    // random: no idling, sender idle, receiver stalls, both
    send_random(100);
    send_idle_pct = 60;
    send_random(100);
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    send_random(100);
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    send_random(100);

    // long receiver hold-off while the sender keeps offering beats
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 60;
    send_random(20);

    // drop valid at the accepting edge of the last beat
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Run covered %0d operation beats and %0d checked results,", n_sent,
             checked_count);
    $display("including %0d inserts dropped on full and %0d pops on empty.",
             dropped_count, empty_pop_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Timeout waiting for the queue to finish");
    $display("Some tests failed");
    $finish;
  end

endmodule
